// ----- sv/char_lcd_text_nibble_writer_assert.svh -----
// Assertion macros shared by the LCD nibble writer modules.
`ifndef CHAR_LCD_TEXT_NIBBLE_WRITER_ASSERT_SVH
`define CHAR_LCD_TEXT_NIBBLE_WRITER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define LCDNW_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
`define LCDNW_ASSERT_NEXT(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define LCDNW_ASSERT(lbl, clk, rst, prop)
`define LCDNW_ASSERT_NEXT(lbl, clk, rst, pre, post)
`endif

`endif

// ----- sv/lcdnw_pkg.sv -----
// Types, constants and helper functions for the LCD nibble writer.
`timescale 1ns / 1ps
package lcdnw_pkg;

  localparam int COL_W  = 6;
  localparam int ROW_W  = 2;
  localparam int RCNT_W = 3;
  localparam int BYTE_W = 8;
  localparam int NIB_W  = 4;
  localparam int CFG_DATA_W = 6;

  localparam int QUEUE_DEPTH_DEFAULT = 4;

  localparam logic [COL_W-1:0]  COLUMN_COUNT_RESET = 6'd16;
  localparam logic [RCNT_W-1:0] ROW_COUNT_RESET    = 3'd2;
  localparam logic [RCNT_W-1:0] ROW_OFFSET_COUNT   = 3'd4;

  localparam logic [BYTE_W-1:0] DDRAM_SET  = 8'h80;
  localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [NIB_W-1:0]  NIB_MASK   = 4'hF;

  localparam logic CFG_COLUMN_COUNT = 1'b0;
  localparam logic CFG_ROW_COUNT    = 1'b1;

  localparam logic RS_COMMAND = 1'b0;
  localparam logic RS_DATA    = 1'b1;

  typedef enum logic [1:0] {
    ACT_TEXT = 2'd0,
    ACT_MOVE = 2'd1,
    ACT_CMD  = 2'd2,
    ACT_DATA = 2'd3
  } action_t;

  // One byte write request for the bus side.
  typedef struct packed {
    logic              rs;
    logic [BYTE_W-1:0] data;
    logic              last;
  } lcd_req_t;

  function automatic logic [BYTE_W-1:0] row_base(input logic [ROW_W-1:0] row);
    logic [BYTE_W-1:0] base;
    case (row)
      2'd0:    base = 8'h00;
      2'd1:    base = 8'h40;
      2'd2:    base = 8'h14;
      2'd3:    base = 8'h54;
      default: base = 8'h00;
    endcase
    return base;
  endfunction

  // Rows at or beyond the display height (or the offset table) go to row 0.
  function automatic logic [ROW_W-1:0] fix_row(input logic [RCNT_W-1:0] row,
                                               input logic [RCNT_W-1:0] rows);
    logic [ROW_W-1:0] r;
    if (row >= rows || row >= ROW_OFFSET_COUNT) begin
      r = '0;
    end else begin
      r = row[ROW_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [BYTE_W-1:0] ddram_cmd(input logic [COL_W-1:0] col,
                                                  input logic [ROW_W-1:0] row);
    logic [BYTE_W-1:0] addr;
    addr = {{(BYTE_W-COL_W){1'b0}}, col} + row_base(row);
    return DDRAM_SET | addr;
  endfunction

endpackage

// ----- sv/lcdnw_front.sv -----
// Front end: takes requests, tracks the cursor and issues byte writes.
`timescale 1ns / 1ps
module lcdnw_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic [1:0]                     action,
  input  logic [lcdnw_pkg::BYTE_W-1:0]   byte_value,
  input  logic [lcdnw_pkg::COL_W-1:0]    target_column,
  input  logic [lcdnw_pkg::RCNT_W-1:0]   target_row,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic                           cfg_index,
  input  logic [lcdnw_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                           q_push,
  input  logic                           q_full,
  output lcdnw_pkg::lcd_req_t            q_req
);
  import lcdnw_pkg::*;

  `include "char_lcd_text_nibble_writer_assert.svh"

  logic [COL_W-1:0]  column_count;
  logic [RCNT_W-1:0] row_count;
  logic [COL_W-1:0]  cursor_column, cursor_column_next;
  logic [ROW_W-1:0]  cursor_row, cursor_row_next;
  logic [1:0]        pend_count, pend_count_next;
  lcd_req_t          pend0, pend1, pend0_next, pend1_next;

  logic              in_acc, q_acc, wrap;
  logic [ROW_W-1:0]  r1, r_nl, r_cr, r_mv;
  logic [COL_W-1:0]  c1;
  lcd_req_t          wrap_req, main_req;
  logic [1:0]        n_req;
  action_t           act;

  assign cfg_ready = 1'b1;
  assign act       = action_t'(action);
  assign q_acc     = q_push && !q_full;
  assign q_push    = pend_count != 2'd0;
  assign q_req     = pend0;
  assign full      = !(pend_count == 2'd0 || (pend_count == 2'd1 && q_acc));
  assign in_acc    = push && !full;

  always_comb begin
    wrap = cursor_column >= column_count;
    r1   = wrap ? fix_row({1'b0, cursor_row} + 3'd1, row_count) : cursor_row;
    c1   = wrap ? '0 : cursor_column;
    r_nl = fix_row({1'b0, r1} + 3'd1, row_count);
    r_cr = fix_row({1'b0, r1}, row_count);
    r_mv = fix_row(target_row, row_count);

    wrap_req = '{rs: RS_COMMAND, data: ddram_cmd('0, r1), last: 1'b0};
    main_req = '{rs: RS_DATA, data: byte_value, last: 1'b1};
    cursor_column_next = cursor_column;
    cursor_row_next    = cursor_row;
    n_req              = 2'd1;

    case (act)
      ACT_TEXT: begin
        if (byte_value == CHAR_NUL) begin
          n_req = 2'd0;
        end else begin
          n_req = wrap ? 2'd2 : 2'd1;
          if (byte_value == CHAR_LF) begin
            main_req           = '{rs: RS_COMMAND, data: ddram_cmd(c1, r_nl), last: 1'b1};
            cursor_column_next = c1;
            cursor_row_next    = r_nl;
          end else if (byte_value == CHAR_CR) begin
            main_req           = '{rs: RS_COMMAND, data: ddram_cmd('0, r_cr), last: 1'b1};
            cursor_column_next = '0;
            cursor_row_next    = r_cr;
          end else begin
            cursor_column_next = c1 + 6'd1;
            cursor_row_next    = r1;
          end
        end
      end
      ACT_MOVE: begin
        main_req           = '{rs: RS_COMMAND, data: ddram_cmd(target_column, r_mv),
                               last: 1'b1};
        cursor_column_next = target_column;
        cursor_row_next    = r_mv;
      end
      ACT_CMD: begin
        main_req = '{rs: RS_COMMAND, data: byte_value, last: 1'b1};
      end
      default: begin
        main_req = '{rs: RS_DATA, data: byte_value, last: 1'b1};
      end
    endcase
  end

  always_comb begin
    pend_count_next = pend_count;
    pend0_next      = pend0;
    pend1_next      = pend1;
    if (in_acc) begin
      pend_count_next = n_req;
      pend0_next      = (n_req == 2'd2) ? wrap_req : main_req;
      pend1_next      = main_req;
    end else if (q_acc) begin
      pend_count_next = pend_count - 2'd1;
      pend0_next      = pend1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count  <= COLUMN_COUNT_RESET;
      row_count     <= ROW_COUNT_RESET;
      cursor_column <= '0;
      cursor_row    <= '0;
      pend_count    <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_COLUMN_COUNT: column_count <= cfg_data[COL_W-1:0];
          CFG_ROW_COUNT:    row_count    <= cfg_data[RCNT_W-1:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        cursor_column <= cursor_column_next;
        cursor_row    <= cursor_row_next;
      end
      pend_count <= pend_count_next;
    end
  end

  always_ff @(posedge clk) begin
    pend0 <= pend0_next;
    pend1 <= pend1_next;
  end

  `LCDNW_ASSERT(a_pend_busy, clk, rst, (pend_count != 2'd2) || full)

endmodule

// ----- sv/lcdnw_queue.sv -----
// Short request queue between the front end and the bus side.
`timescale 1ns / 1ps
module lcdnw_queue #(
  parameter int DEPTH = lcdnw_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  lcdnw_pkg::lcd_req_t wr_req,
  input  logic                pop,
  output logic                empty,
  output lcdnw_pkg::lcd_req_t rd_req
);
  import lcdnw_pkg::*;

  `include "char_lcd_text_nibble_writer_assert.svh"

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  lcd_req_t          entries [DEPTH];
  logic [PtrW-1:0]   wr_ptr, rd_ptr;
  logic [CntW-1:0]   count;
  logic              wr_en, rd_en;

  assign full   = count == CntW'(DEPTH);
  assign empty  = count == '0;
  assign wr_en  = push && !full;
  assign rd_en  = pop && !empty;
  assign rd_req = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_req;
    end
  end

  `LCDNW_ASSERT(a_count_bound, clk, rst, count <= CntW'(DEPTH))
  `LCDNW_ASSERT_NEXT(a_count_inc, clk, rst, wr_en && !rd_en, count == $past(count) + 1'b1)

endmodule

// ----- sv/lcdnw_back.sv -----
// Bus side: splits each byte write into two nibble writes, high nibble first.
`timescale 1ns / 1ps
module lcdnw_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_empty,
  output logic                         q_pop,
  input  lcdnw_pkg::lcd_req_t          q_req,
  output logic                         empty,
  input  logic                         pop,
  output logic                         register_select,
  output logic [lcdnw_pkg::NIB_W-1:0]  nibble,
  output logic                         last
);
  import lcdnw_pkg::*;

  `include "char_lcd_text_nibble_writer_assert.svh"

  logic             out_valid, lo_pending;
  logic             out_rs, out_last, lo_rs, lo_last;
  logic [NIB_W-1:0] out_nib, lo_nib;
  logic             slot_free;

  assign slot_free       = !out_valid || pop;
  assign q_pop           = slot_free && !lo_pending && !q_empty;
  assign empty           = !out_valid;
  assign register_select = out_rs;
  assign nibble          = out_nib;
  assign last            = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      lo_pending <= 1'b0;
    end else if (slot_free) begin
      if (lo_pending) begin
        out_valid  <= 1'b1;
        lo_pending <= 1'b0;
      end else begin
        out_valid  <= !q_empty;
        lo_pending <= !q_empty;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free) begin
      if (lo_pending) begin
        out_rs   <= lo_rs;
        out_nib  <= lo_nib;
        out_last <= lo_last;
      end else if (!q_empty) begin
        out_rs   <= q_req.rs;
        out_nib  <= q_req.data[BYTE_W-1:NIB_W];
        out_last <= 1'b0;
        lo_rs    <= q_req.rs;
        lo_nib   <= q_req.data[NIB_W-1:0] & NIB_MASK;
        lo_last  <= q_req.last;
      end
    end
  end

  `LCDNW_ASSERT(a_lo_needs_out, clk, rst, !lo_pending || out_valid)
  `LCDNW_ASSERT(a_last_is_low, clk, rst, !(out_valid && out_last) || !lo_pending)

endmodule

// ----- sv/char_lcd_text_nibble_writer.sv -----
// Top level of the character LCD 4-bit nibble writer.
// Data path: front pending buffer, then the queue, then the back output register.
// Throughput: one nibble per cycle on the result side while pop stays high; an item
//   yields 0, 2 or 4 nibbles, so the output side sets the sustained item rate.
// Input takes an item each cycle while the front byte buffer and queue have room.
// Reset: cursor at column 0 row 0, column_count 16, row_count 2, queue empty.
`timescale 1ns / 1ps
module char_lcd_text_nibble_writer #(
  parameter int QUEUE_DEPTH = lcdnw_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  logic [1:0]                       action,
  input  logic [lcdnw_pkg::BYTE_W-1:0]     byte_value,
  input  logic [lcdnw_pkg::COL_W-1:0]      target_column,
  input  logic [lcdnw_pkg::RCNT_W-1:0]     target_row,
  output logic                             empty,
  input  logic                             pop,
  output logic                             register_select,
  output logic [lcdnw_pkg::NIB_W-1:0]      nibble,
  output logic                             last,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic                             cfg_index,
  input  logic [lcdnw_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lcdnw_pkg::*;

  logic     fq_push, fq_full, bq_empty, bq_pop;
  lcd_req_t fq_req, bq_req;

  lcdnw_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .action        (action),
    .byte_value    (byte_value),
    .target_column (target_column),
    .target_row    (target_row),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .q_push        (fq_push),
    .q_full        (fq_full),
    .q_req         (fq_req)
  );

  lcdnw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (fq_push),
    .full   (fq_full),
    .wr_req (fq_req),
    .pop    (bq_pop),
    .empty  (bq_empty),
    .rd_req (bq_req)
  );

  lcdnw_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_empty         (bq_empty),
    .q_pop           (bq_pop),
    .q_req           (bq_req),
    .empty           (empty),
    .pop             (pop),
    .register_select (register_select),
    .nibble          (nibble),
    .last            (last)
  );

endmodule

// ----- tb/char_lcd_text_nibble_writer_test.sv -----
// Testbench for char_lcd_text_nibble_writer: directed and random requests checked against a predictor.
`timescale 1ns / 1ps
module char_lcd_text_nibble_writer_test;
  import lcdnw_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    logic             rs;
    logic [NIB_W-1:0] nib;
    logic             last;
  } nibble_write_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic [1:0] action = ACT_TEXT;
  logic [BYTE_W-1:0] byte_value = '0;
  logic [COL_W-1:0] target_column = '0;
  logic [RCNT_W-1:0] target_row = '0;
  logic empty;
  logic pop = 1'b0;
  logic register_select;
  logic [NIB_W-1:0] nibble;
  logic last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = CFG_COLUMN_COUNT;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Predicted display state and settings
  logic [COL_W-1:0] cur_col = '0;
  logic [ROW_W-1:0] cur_row = '0;
  logic [COL_W-1:0] col_cnt = COLUMN_COUNT_RESET;
  logic [RCNT_W-1:0] row_cnt = ROW_COUNT_RESET;

  nibble_write_t nibbles_due[$];
  nibble_write_t due_now;

  int mismatches = 0;
  int requests_taken = 0;
  int nibbles_seen = 0;
  int setting_writes = 0;
  int burst_left = 0;
  int cycles = 0;
  int stall_mode = 0;

  char_lcd_text_nibble_writer uut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .action(action),
    .byte_value(byte_value),
    .target_column(target_column),
    .target_row(target_row),
    .empty(empty),
    .pop(pop),
    .register_select(register_select),
    .nibble(nibble),
    .last(last),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [BYTE_W-1:0] line_start(input logic [ROW_W-1:0] r);
    logic [BYTE_W-1:0] a;
    case (r)
      2'd0: a = 8'h00;
      2'd1: a = 8'h40;
      2'd2: a = 8'h14;
      default: a = 8'h54;
    endcase
    return a;
  endfunction

  function automatic void queue_byte(input logic rs, input logic [BYTE_W-1:0] b);
    nibbles_due.push_back('{rs: rs, nib: b[7:4], last: 1'b0});
    nibbles_due.push_back('{rs: rs, nib: b[3:0], last: 1'b0});
  endfunction

  function automatic void goto_cell(input int col, input int row);
    logic [BYTE_W-1:0] addr;
    if (row >= int'(row_cnt) || row >= 4) row = 0;
    cur_col = col[COL_W-1:0];
    cur_row = row[ROW_W-1:0];
    addr = {2'b00, cur_col} + line_start(cur_row);
    queue_byte(RS_COMMAND, DDRAM_SET | addr);
  endfunction

  function automatic void predict_nibbles(input action_t act, input logic [BYTE_W-1:0] b,
                                          input logic [COL_W-1:0] tc,
                                          input logic [RCNT_W-1:0] tr);
    int due_before;
    due_before = nibbles_due.size();
    case (act)
      ACT_TEXT: begin
        if (b != CHAR_NUL) begin
          if (cur_col >= col_cnt) goto_cell(0, int'(cur_row) + 1);
          if (b == CHAR_LF) begin
            goto_cell(int'(cur_col), int'(cur_row) + 1);
          end else if (b == CHAR_CR) begin
            goto_cell(0, int'(cur_row));
          end else begin
            queue_byte(RS_DATA, b);
            cur_col = cur_col + 1'b1;
          end
        end
      end
      ACT_MOVE: goto_cell(int'(tc), int'(tr));
      ACT_CMD: queue_byte(RS_COMMAND, b);
      default: queue_byte(RS_DATA, b);
    endcase
    if (nibbles_due.size() > due_before) nibbles_due[nibbles_due.size() - 1].last = 1'b1;
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  always @(posedge clk) begin
    if (!rst && push && !full) begin
      requests_taken++;
      predict_nibbles(action_t'(action), byte_value, target_column, target_row);
    end
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      nibbles_seen++;
      if (nibbles_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected nibble rs=%0b nib=%h last=%0b",
                                register_select, nibble, last));
      end else begin
        due_now = nibbles_due.pop_front();
        if (register_select !== due_now.rs)
          flag_mismatch($sformatf("register_select %0b, expected %0b", register_select,
                                  due_now.rs));
        if (nibble !== due_now.nib)
          flag_mismatch($sformatf("nibble %h, expected %h", nibble, due_now.nib));
        if (last !== due_now.last)
          flag_mismatch($sformatf("last %0b, expected %0b", last, due_now.last));
      end
    end
  end

  // Receiver stall pattern and run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles % 256 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: pop <= 1'b1;
      1: pop <= ($urandom_range(0, 9) < 7);
      2: pop <= (cycles % 11) >= 3;
      default: pop <= (cycles % 40) >= 25;
    endcase
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_item(input action_t act, input logic [BYTE_W-1:0] b,
                           input logic [COL_W-1:0] tc, input logic [RCNT_W-1:0] tr);
    int gap;
    if (burst_left == 0) begin
      if (push) push <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    push <= 1'b1;
    action <= act;
    byte_value <= b;
    target_column <= tc;
    target_row <= tr;
    do @(posedge clk); while (full);
    burst_left--;
  endtask

  // Sends with random content in the fields the action ignores.
  task automatic send_text(input logic [BYTE_W-1:0] b);
    send_item(ACT_TEXT, b, COL_W'($urandom_range(0, 63)), RCNT_W'($urandom_range(0, 7)));
  endtask

  task automatic send_move(input logic [COL_W-1:0] tc, input logic [RCNT_W-1:0] tr);
    send_item(ACT_MOVE, BYTE_W'($urandom_range(0, 255)), tc, tr);
  endtask

  task automatic send_raw(input action_t act, input logic [BYTE_W-1:0] b);
    send_item(act, b, COL_W'($urandom_range(0, 63)), RCNT_W'($urandom_range(0, 7)));
  endtask

  task automatic settle();
    push <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (nibbles_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_setting(input logic idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    setting_writes++;
    if (idx == CFG_COLUMN_COUNT) col_cnt = val;
    else row_cnt = val[RCNT_W-1:0];
  endtask

  task automatic apply_layout(input int cols, input int rows);
    settle();
    write_setting(CFG_COLUMN_COUNT, cols[CFG_DATA_W-1:0]);
    write_setting(CFG_ROW_COUNT, rows[CFG_DATA_W-1:0]);
  endtask

  task automatic test_raw_bytes();
    send_raw(ACT_CMD, 8'h00);
    send_raw(ACT_CMD, 8'hFF);
    send_raw(ACT_DATA, 8'h00);
    send_raw(ACT_DATA, 8'hFF);
    send_raw(ACT_DATA, 8'hA5);
  endtask

  task automatic test_cursor_moves();
    send_move(6'd0, 3'd0);
    send_move(6'd63, 3'd7);
    send_move(6'd39, 3'd1);
    send_move(6'd5, 3'd3);
  endtask

  task automatic test_text_chars();
    send_text(CHAR_NUL);
    send_text(8'h41);
    send_text(8'hFF);
    send_text(CHAR_LF);
    send_text(CHAR_CR);
  endtask

  task automatic test_line_wrap();
    send_move(6'd15, 3'd1);
    send_text(8'h78);
    send_move(6'd16, 3'd1);
    send_text(CHAR_LF);
  endtask

  task automatic test_layout_extremes();
    apply_layout(0, 0);
    send_text(8'h5A);
    send_text(CHAR_CR);
    apply_layout(63, 7);
    send_move(6'd63, 3'd7);
    send_move(6'd10, 3'd3);
    send_text(CHAR_LF);
    send_text(8'h30);
  endtask

  task automatic send_random_item();
    int pick;
    int ch;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      ch = $urandom_range(0, 99);
      if (ch < 4) send_text(CHAR_NUL);
      else if (ch < 12) send_text(CHAR_LF);
      else if (ch < 20) send_text(CHAR_CR);
      else send_text(BYTE_W'($urandom_range(1, 255)));
    end else if (pick < 70) begin
      send_move(COL_W'($urandom_range(0, 63)), RCNT_W'($urandom_range(0, 7)));
    end else if (pick < 85) begin
      send_raw(ACT_CMD, BYTE_W'($urandom_range(0, 255)));
    end else begin
      send_raw(ACT_DATA, BYTE_W'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_random_traffic();
    int col_plan [8];
    int row_plan [8];
    col_plan = '{16, 1, 40, 0, 63, 20, 8, 0};
    row_plan = '{2, 1, 4, 0, 7, 3, 4, 0};
    col_plan[7] = $urandom_range(1, 40);
    row_plan[7] = $urandom_range(1, 4);
    for (int p = 0; p < 8; p++) begin
      apply_layout(col_plan[p], row_plan[p]);
      repeat (55) send_random_item();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_raw_bytes();
    test_cursor_moves();
    test_text_chars();
    test_line_wrap();
    test_layout_extremes();
    test_random_traffic();
    settle();
    repeat (20) @(posedge clk);
    $display("Ran %0d requests (text, moves, raw bytes) over %0d register writes,",
             requests_taken, setting_writes);
    $display("checking %0d nibble writes with wraps, row folding and receiver stalls.",
             nibbles_seen);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
